// ----- rtl/ocsi_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and command/status types of the spline interpolator.
package ocsi_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COEF_W          = 48;
    // divider numerator width: covers 3s - (cs + 2ps) with headroom
    localparam int NUM_W           = COEF_W + 4;
    localparam int MUL_CHUNK       = 16;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_PUSH    = 2'd1,
        OP_EVAL    = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q1,
        S_Q2,
        S_SLOPE,
        S_C2,
        S_C3A,
        S_C3B,
        S_RATIO,
        S_LIN,
        S_M3,
        S_M2,
        S_M1,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_RESTART,
        ACT_PUSH,
        ACT_CAPTURE
    } t_act;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_Q1,
        STEP_Q2,
        STEP_C2,
        STEP_C3A,
        STEP_C3B,
        STEP_RATIO,
        STEP_LIN,
        STEP_M3,
        STEP_M2,
        STEP_M1
    } t_step;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_REJECT,
        RES_EVAL
    } t_res;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_SETUP,
        DV_RUN,
        DV_FIN
    } t_div_state;

    typedef enum logic [1:0] {
        ML_IDLE,
        ML_RUN,
        ML_FIN
    } t_mul_state;

    typedef struct packed {
        t_act  act;
        t_step step;
        logic  div_go;
        logic  mul_go;
        logic  slope;
        logic  res_load;
        t_res  res_kind;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic dt_zero;
        logic out_full;
    } t_status;

endpackage

// ----- rtl/ocsi_div.sv -----
`timescale 1ns / 1ps
// Restoring fixed-point divider, one quotient bit per cycle, saturating to coefficient width.
module ocsi_div #(
    parameter int VALUE_WIDTH = ocsi_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = ocsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic signed [ocsi_pkg::NUM_W-1:0]   i_num,
    input  logic        [VALUE_WIDTH-1:0]       i_den,
    output logic                                o_done,
    output logic signed [ocsi_pkg::COEF_W-1:0]  o_quo
);
    import ocsi_pkg::*;

    localparam int CNT_W = $clog2(COEF_W + 1);
    localparam int SHW   = NUM_W + FRAC_BITS;
    localparam logic [COEF_W-1:0] CMAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] CMIN = {1'b1, {(COEF_W-1){1'b0}}};

    t_div_state r_st, n_st;
    logic [NUM_W-1:0]       r_mag;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_den;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [COEF_W-1:0]      r_nb;
    logic [COEF_W-1:0]      r_q;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_ovf;
    logic [COEF_W-1:0]      r_res;
    logic                   r_done;

    logic [NUM_W-1:0]     num_mag;
    logic [NUM_W-1:0]     hi;
    logic [SHW-1:0]       sh;
    logic                 ovf;
    logic                 zero;
    logic [VALUE_WIDTH:0] trial;
    logic [VALUE_WIDTH:0] diff;
    logic                 ge;
    logic [COEF_W-1:0]    res;

    assign num_mag = i_num[NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
    // quotient reaches 2^COEF_W exactly when the top of the numerator reaches the divisor
    assign hi      = r_mag >> (COEF_W - FRAC_BITS);
    assign ovf     = hi >= NUM_W'(r_den);
    assign zero    = (r_mag == '0);
    assign sh      = {r_mag, {FRAC_BITS{1'b0}}};
    assign trial   = {r_rem, r_nb[COEF_W-1]};
    assign diff    = trial - {1'b0, r_den};
    assign ge      = trial >= {1'b0, r_den};

    always_comb begin
        if (r_ovf) begin
            res = r_neg ? CMIN : CMAX;
        end else if (!r_neg) begin
            res = r_q[COEF_W-1] ? CMAX : r_q;
        end else begin
            res = (r_q[COEF_W-1] && (|r_q[COEF_W-2:0])) ? CMIN : (~r_q + 1'b1);
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            DV_IDLE:  if (i_go) n_st = DV_SETUP;
            DV_SETUP: n_st = (zero || ovf) ? DV_FIN : DV_RUN;
            DV_RUN:   if (r_cnt == CNT_W'(1)) n_st = DV_FIN;
            DV_FIN:   n_st = DV_IDLE;
            default:  n_st = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= DV_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == DV_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            DV_IDLE: begin
                if (i_go) begin
                    r_mag <= num_mag;
                    r_neg <= i_num[NUM_W-1];
                    r_den <= i_den;
                end
            end
            DV_SETUP: begin
                r_q   <= '0;
                r_ovf <= ovf && !zero;
                r_rem <= hi[VALUE_WIDTH-1:0];
                r_nb  <= sh[COEF_W-1:0];
                r_cnt <= CNT_W'(COEF_W);
            end
            DV_RUN: begin
                r_rem <= ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
                r_q   <= {r_q[COEF_W-2:0], ge};
                r_nb  <= {r_nb[COEF_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            DV_FIN: r_res <= res;
            default: r_res <= r_res;
        endcase
    end

    assign o_done = r_done;
    assign o_quo  = $signed(r_res);

endmodule

// ----- rtl/ocsi_mul.sv -----
`timescale 1ns / 1ps
// Chunked signed fixed-point multiplier, drops the fraction bits and saturates.
module ocsi_mul #(
    parameter int FRAC_BITS = ocsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_go,
    input  logic signed [ocsi_pkg::COEF_W:0]     i_a,
    input  logic signed [ocsi_pkg::COEF_W:0]     i_b,
    output logic                                 o_done,
    output logic signed [ocsi_pkg::COEF_W-1:0]   o_prod
);
    import ocsi_pkg::*;

    localparam int OP_W  = COEF_W + 1;
    localparam int NCH   = (OP_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BW    = NCH * MUL_CHUNK;
    localparam int PW    = OP_W + BW;
    localparam int CNT_W = $clog2(NCH + 1);
    localparam logic [COEF_W-1:0] CMAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] CMIN = {1'b1, {(COEF_W-1){1'b0}}};

    t_mul_state r_st, n_st;
    logic [OP_W-1:0]   r_a;
    logic [BW-1:0]     r_b;
    logic [PW-1:0]     r_p;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [COEF_W-1:0] r_res;
    logic              r_done;

    logic [OP_W-1:0]           a_mag;
    logic [OP_W-1:0]           b_mag;
    logic [OP_W+MUL_CHUNK-1:0] partial;
    logic [PW-1:0]             sh;
    logic                      ovf_pos;
    logic                      ovf_neg;
    logic [COEF_W-1:0]         res;

    assign a_mag   = i_a[OP_W-1] ? $unsigned(-i_a) : $unsigned(i_a);
    assign b_mag   = i_b[OP_W-1] ? $unsigned(-i_b) : $unsigned(i_b);
    assign partial = r_a * r_b[BW-1 -: MUL_CHUNK];
    assign sh      = r_p >> FRAC_BITS;
    assign ovf_pos = |sh[PW-1:COEF_W-1];
    assign ovf_neg = (|sh[PW-1:COEF_W]) || (sh[COEF_W-1] && (|sh[COEF_W-2:0]));

    always_comb begin
        if (r_neg) begin
            res = ovf_neg ? CMIN : (~sh[COEF_W-1:0] + 1'b1);
        end else begin
            res = ovf_pos ? CMAX : sh[COEF_W-1:0];
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ML_IDLE: if (i_go) n_st = ML_RUN;
            ML_RUN:  if (r_cnt == CNT_W'(1)) n_st = ML_FIN;
            ML_FIN:  n_st = ML_IDLE;
            default: n_st = ML_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ML_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == ML_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ML_IDLE: begin
                if (i_go) begin
                    r_a   <= a_mag;
                    r_b   <= BW'(b_mag);
                    r_neg <= i_a[OP_W-1] ^ i_b[OP_W-1];
                    r_p   <= '0;
                    r_cnt <= CNT_W'(NCH);
                end
            end
            ML_RUN: begin
                // top chunk of the multiplier first
                r_p   <= (r_p << MUL_CHUNK) + PW'(partial);
                r_b   <= r_b << MUL_CHUNK;
                r_cnt <= r_cnt - 1'b1;
            end
            ML_FIN: r_res <= res;
            default: r_res <= r_res;
        endcase
    end

    assign o_done = r_done;
    assign o_prod = $signed(r_res);

endmodule

// ----- rtl/ocsi_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences restart, push and evaluate over the shared units.
module ocsi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_operation,
    input  logic              i_out_ready,
    input  ocsi_pkg::t_status i_st,
    output logic              o_in_ready,
    output ocsi_pkg::t_cmd    o_cmd
);
    import ocsi_pkg::*;

    t_state r_state, n_state;
    logic   r_issued, n_issued;
    t_res   r_kind, n_kind;

    t_op    op;
    logic   use_div;
    logic   use_mul;
    t_state next_unit;
    t_res   fin_kind;

    assign op = t_op'(i_operation);

    always_comb begin
        n_state   = r_state;
        n_issued  = r_issued;
        n_kind    = r_kind;
        o_in_ready = 1'b0;
        use_div   = 1'b0;
        use_mul   = 1'b0;
        next_unit = S_IDLE;
        fin_kind  = r_kind;
        o_cmd.act      = ACT_NONE;
        o_cmd.step     = STEP_NONE;
        o_cmd.div_go   = 1'b0;
        o_cmd.mul_go   = 1'b0;
        o_cmd.slope    = 1'b0;
        o_cmd.res_load = 1'b0;
        o_cmd.res_kind = r_kind;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (op)
                        OP_RESTART: begin
                            o_cmd.act = ACT_RESTART;
                            n_kind    = RES_ZERO;
                            n_state   = S_RESULT;
                        end
                        OP_PUSH: begin
                            if (i_st.dt_zero) begin
                                n_kind  = RES_REJECT;
                                n_state = S_RESULT;
                            end else begin
                                o_cmd.act = ACT_PUSH;
                                n_state   = S_Q1;
                            end
                        end
                        OP_EVAL: begin
                            o_cmd.act = ACT_CAPTURE;
                            n_state   = S_RATIO;
                        end
                        default: begin
                            n_kind  = RES_ZERO;
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_Q1:    begin o_cmd.step = STEP_Q1;    use_div = 1'b1; next_unit = S_Q2;    end
            S_Q2:    begin o_cmd.step = STEP_Q2;    use_div = 1'b1; next_unit = S_SLOPE; end
            S_SLOPE: begin
                o_cmd.slope = 1'b1;
                n_state     = S_C2;
            end
            S_C2:    begin o_cmd.step = STEP_C2;    use_div = 1'b1; next_unit = S_C3A;   end
            S_C3A:   begin o_cmd.step = STEP_C3A;   use_div = 1'b1; next_unit = S_C3B;   end
            S_C3B: begin
                o_cmd.step = STEP_C3B;
                use_div    = 1'b1;
                next_unit  = S_RESULT;
                fin_kind   = RES_ZERO;
            end
            S_RATIO: begin o_cmd.step = STEP_RATIO; use_div = 1'b1; next_unit = S_LIN;   end
            S_LIN:   begin o_cmd.step = STEP_LIN;   use_mul = 1'b1; next_unit = S_M3;    end
            S_M3:    begin o_cmd.step = STEP_M3;    use_mul = 1'b1; next_unit = S_M2;    end
            S_M2:    begin o_cmd.step = STEP_M2;    use_mul = 1'b1; next_unit = S_M1;    end
            S_M1: begin
                o_cmd.step = STEP_M1;
                use_mul    = 1'b1;
                next_unit  = S_RESULT;
                fin_kind   = RES_EVAL;
            end
            S_RESULT: begin
                // hold until the output register is free or draining
                if (!i_st.out_full || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (use_div || use_mul) begin
            if (!r_issued) begin
                o_cmd.div_go = use_div;
                o_cmd.mul_go = use_mul;
                n_issued     = 1'b1;
            end else if ((use_div && i_st.div_done) || (use_mul && i_st.mul_done)) begin
                n_issued = 1'b0;
                n_kind   = fin_kind;
                n_state  = next_unit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_kind   <= RES_ZERO;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_kind   <= n_kind;
        end
    end

`ifndef SYNTHESIS
    a_go_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_go || o_cmd.mul_go) |=> !(o_cmd.div_go || o_cmd.mul_go))
        else $error("unit start pulse lasted more than one cycle");
    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_st.div_done || i_st.mul_done) |-> r_issued)
        else $error("unit finished without a pending request");
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_issued)
        else $error("request left pending in idle");
    a_load_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> i_st.out_full)
        else $error("result load did not fill the output register");
`endif

endmodule

// ----- rtl/ocsi_dp.sv -----
`timescale 1ns / 1ps
// Datapath: sample state, coefficients, operand selection, shared divider and multiplier.
module ocsi_dp #(
    parameter int VALUE_WIDTH = ocsi_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = ocsi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ocsi_pkg::t_cmd                i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_sample_value,
    input  logic        [VALUE_WIDTH-1:0] i_interval,
    input  logic        [VALUE_WIDTH-1:0] i_eval_offset,
    input  logic                          i_out_ready,
    output ocsi_pkg::t_status             o_st,
    output logic                          o_out_valid,
    output logic signed [VALUE_WIDTH-1:0] o_linear_value,
    output logic signed [VALUE_WIDTH-1:0] o_spline_value,
    output logic                          o_status
);
    import ocsi_pkg::*;

    localparam int VW   = VALUE_WIDTH;
    localparam int CW   = COEF_W;
    localparam int SW   = CW + 1;
    localparam logic [VW-1:0] ONE_Q = VW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] V_MAX = SW'({(VW-1){1'b1}});
    localparam logic signed [SW-1:0] V_MIN = ~V_MAX;
    localparam logic signed [SW-1:0] C_MAX = SW'({(CW-1){1'b1}});
    localparam logic signed [SW-1:0] C_MIN = ~C_MAX;

    logic signed [VW-1:0] r_prev, r_cur, r_next, r_ps, r_cs;
    logic        [VW-1:0] r_act, r_up, r_t;
    logic signed [CW-1:0] r_c0, r_c1, r_c2, r_c3;
    logic signed [CW-1:0] r_q1, r_s, r_tmp, r_acc;
    logic signed [VW-1:0] r_lin, r_spl;
    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_lin, r_out_spl;
    logic                 r_out_status;

    logic signed [VW:0]    d_cur_prev, d_next_cur;
    logic signed [NUM_W-1:0] s_x, cs_x, ps_x, n2, n3;
    logic signed [NUM_W-1:0] div_num;
    logic        [VW-1:0]    div_den;
    logic signed [CW:0]      mul_a, mul_b;
    logic                    div_done, mul_done;
    logic signed [CW-1:0]    div_quo, mul_prod;
    logic signed [SW-1:0]    slope_sum, slope_adj, slope_half, slope_sat;
    logic signed [SW-1:0]    lin_sum, lin_sat, acc_sum, acc_sat, spl_sum, spl_sat;
    logic signed [CW-1:0]    acc_base;

    assign d_cur_prev = (VW+1)'(r_cur) - (VW+1)'(r_prev);
    assign d_next_cur = (VW+1)'(r_next) - (VW+1)'(r_cur);

    assign s_x  = NUM_W'(r_s);
    assign cs_x = NUM_W'(r_cs);
    assign ps_x = NUM_W'(r_ps);
    assign n2   = s_x + s_x + s_x - cs_x - ps_x - ps_x;
    assign n3   = cs_x + ps_x - s_x - s_x;

    always_comb begin
        div_num = NUM_W'(d_cur_prev);
        div_den = r_act;
        case (i_cmd.step)
            STEP_Q1: begin
                div_num = NUM_W'(d_next_cur);
                div_den = r_up;
            end
            STEP_Q2:    div_num = NUM_W'(d_cur_prev);
            STEP_C2:    div_num = n2;
            STEP_C3A:   div_num = n3;
            STEP_C3B:   div_num = NUM_W'(r_tmp);
            STEP_RATIO: div_num = $signed(NUM_W'(r_t));
            default:    div_num = NUM_W'(d_cur_prev);
        endcase
    end

    always_comb begin
        mul_a = (CW+1)'(r_acc);
        mul_b = $signed((CW+1)'(r_t));
        case (i_cmd.step)
            STEP_LIN: begin
                mul_a = (CW+1)'(d_cur_prev);
                mul_b = (CW+1)'(r_tmp);
            end
            STEP_M3: mul_a = (CW+1)'(r_c3);
            default: mul_a = (CW+1)'(r_acc);
        endcase
    end

    ocsi_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ocsi_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // halve toward zero: bias negative sums by one before the shift
    assign slope_sum  = SW'(r_q1) + SW'(r_s);
    assign slope_adj  = slope_sum + $signed(SW'(slope_sum[SW-1]));
    assign slope_half = slope_adj >>> 1;
    assign slope_sat  = (slope_half > V_MAX) ? V_MAX : (slope_half < V_MIN) ? V_MIN : slope_half;

    assign lin_sum  = SW'(r_prev) + SW'(mul_prod);
    assign lin_sat  = (lin_sum > V_MAX) ? V_MAX : (lin_sum < V_MIN) ? V_MIN : lin_sum;
    assign acc_base = (i_cmd.step == STEP_M3) ? r_c2 : r_c1;
    assign acc_sum  = SW'(acc_base) + SW'(mul_prod);
    assign acc_sat  = (acc_sum > C_MAX) ? C_MAX : (acc_sum < C_MIN) ? C_MIN : acc_sum;
    assign spl_sum  = SW'(r_c0) + SW'(mul_prod);
    assign spl_sat  = (spl_sum > V_MAX) ? V_MAX : (spl_sum < V_MIN) ? V_MIN : spl_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cur  <= '0;
            r_next <= '0;
            r_ps   <= '0;
            r_cs   <= '0;
            r_act  <= ONE_Q;
            r_up   <= ONE_Q;
            r_c0   <= '0;
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
        end else begin
            case (i_cmd.act)
                ACT_RESTART: begin
                    r_prev <= i_sample_value;
                    r_cur  <= i_sample_value;
                    r_next <= i_sample_value;
                    r_ps   <= '0;
                    r_cs   <= '0;
                    r_act  <= ONE_Q;
                    r_up   <= ONE_Q;
                    r_c0   <= '0;
                    r_c1   <= '0;
                    r_c2   <= '0;
                    r_c3   <= '0;
                end
                ACT_PUSH: begin
                    r_prev <= r_cur;
                    r_cur  <= r_next;
                    r_ps   <= r_cs;
                    r_act  <= r_up;
                    r_next <= i_sample_value;
                    r_up   <= i_interval;
                end
                default: r_prev <= r_prev;
            endcase
            if (i_cmd.slope) begin
                r_cs <= slope_sat[VW-1:0];
                r_c0 <= CW'(r_prev);
                r_c1 <= CW'(r_ps);
            end
            if (div_done) begin
                case (i_cmd.step)
                    STEP_C2:  r_c2 <= div_quo;
                    STEP_C3B: r_c3 <= div_quo;
                    default:  r_c2 <= r_c2;
                endcase
            end
        end
    end

    // scratch registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.act == ACT_CAPTURE) begin
            r_t <= i_eval_offset;
        end
        if (div_done) begin
            case (i_cmd.step)
                STEP_Q1:    r_q1  <= div_quo;
                STEP_Q2:    r_s   <= div_quo;
                STEP_C3A:   r_tmp <= div_quo;
                STEP_RATIO: r_tmp <= div_quo;
                default:    r_q1  <= r_q1;
            endcase
        end
        if (mul_done) begin
            case (i_cmd.step)
                STEP_LIN: r_lin <= lin_sat[VW-1:0];
                STEP_M3:  r_acc <= acc_sat[CW-1:0];
                STEP_M2:  r_acc <= acc_sat[CW-1:0];
                STEP_M1:  r_spl <= spl_sat[VW-1:0];
                default:  r_acc <= r_acc;
            endcase
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_kind)
                RES_EVAL: begin
                    r_out_lin    <= r_lin;
                    r_out_spl    <= r_spl;
                    r_out_status <= 1'b0;
                end
                RES_REJECT: begin
                    r_out_lin    <= '0;
                    r_out_spl    <= '0;
                    r_out_status <= 1'b1;
                end
                default: begin
                    r_out_lin    <= '0;
                    r_out_spl    <= '0;
                    r_out_status <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_st.div_done = div_done;
    assign o_st.mul_done = mul_done;
    assign o_st.dt_zero  = (i_interval == '0);
    assign o_st.out_full = r_out_valid;

    assign o_out_valid    = r_out_valid;
    assign o_linear_value = r_out_lin;
    assign o_spline_value = r_out_spl;
    assign o_status       = r_out_status;

endmodule

// ----- rtl/online_cubic_spline_interpolator_unit.sv -----
`timescale 1ns / 1ps
// Online cubic Hermite spline interpolator over timed Q16.16 samples.
//
// Input channel (i_in_valid / o_in_ready) carries one item: operation, sample value,
// interval and evaluation offset. Output channel (o_out_valid / i_out_ready) returns
// exactly one result per item: linear value, spline value and status.
// Restart loads all three points with the sample, clears slopes and coefficients and
// sets both intervals to one. Push with a zero interval is rejected with status 1.
// Items are handled one at a time; o_in_ready is high only while the controller idles.
// Steps per item, from transfer to result valid:
//   restart, rejected push, unknown operation: straight to the result load.
//   push: five passes through the shared one-bit-per-cycle divider (Q1, Q2, C2,
//   C3A, C3B), with the slope update between Q2 and C2.
//   evaluate: one divider pass for the offset ratio, then four multiplier passes
//   (linear, M3, M2, M1).
// The result sits in an output register; the next item is taken while it waits.
// When the receiver stalls, a finished result holds in the controller until the
// output register frees up. Reset is synchronous, active low, and restores the
// state of a restart at zero with no result pending.
module online_cubic_spline_interpolator_unit #(
    parameter int VALUE_WIDTH = ocsi_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = ocsi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic signed [VALUE_WIDTH-1:0] i_sample_value,
    input  logic        [VALUE_WIDTH-1:0] i_interval,
    input  logic        [VALUE_WIDTH-1:0] i_eval_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [VALUE_WIDTH-1:0] o_linear_value,
    output logic signed [VALUE_WIDTH-1:0] o_spline_value,
    output logic                          o_status
);
    import ocsi_pkg::*;

    t_cmd    cmd;
    t_status st;

    ocsi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_ready (i_out_ready),
        .i_st        (st),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    ocsi_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample_value (i_sample_value),
        .i_interval     (i_interval),
        .i_eval_offset  (i_eval_offset),
        .i_out_ready    (i_out_ready),
        .o_st           (st),
        .o_out_valid    (o_out_valid),
        .o_linear_value (o_linear_value),
        .o_spline_value (o_spline_value),
        .o_status       (o_status)
    );

endmodule
